/* hw/rtl/sha512_pkg.sv */
// Package with SHA-512 constants, types and a rotate helper function.
package sha512_pkg;

    localparam int WordWidth   = 64;
    localparam int BlockWords  = 16;
    localparam int HashWords   = 8;
    localparam int Rounds      = 80;

    typedef logic [WordWidth-1:0] word_t;
    typedef logic [3:0]           widx_t;
    typedef logic [6:0]           round_t;

    // Datapath commands from the controller.
    typedef struct packed {
        logic       load_word;    // write block word at widx
        logic [1:0] word_sel;     // source of the block word
        widx_t      widx;
        logic       add_bits;     // add input bit count
        logic       start;        // copy hash into working vars
        logic       round;        // run one round
        round_t     rnd;
        logic       finish;       // add working vars into hash
        logic       reset_hash;   // reload initial hash, clear length
        logic       shift_out;    // rotate hash for output
    } sha512_cmd_t;

    localparam logic [1:0] SelData = 2'd0;
    localparam logic [1:0] SelPad  = 2'd1;
    localparam logic [1:0] SelZero = 2'd2;
    localparam logic [1:0] SelLen  = 2'd3;

    localparam word_t InitHash [HashWords] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam word_t RoundK [Rounds] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (WordWidth - n));
    endfunction

endpackage

/* hw/rtl/sha512_if.sv */
// Valid/ready channel interfaces for message input and digest output.
interface sha512_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
    modport source (output valid, data_word, valid_bytes, last_word, input ready);
    modport sink   (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface sha512_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic        digest_last;
    modport source (output valid, digest_word, digest_last, input ready);
    modport sink   (input valid, digest_word, digest_last, output ready);
endinterface

/* hw/rtl/sha512_datapath.sv */
// Datapath: block buffer, message schedule, round logic and hash registers.
module sha512_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha512_pkg::sha512_cmd_t cmd,
    input  logic [63:0]           data_word,
    input  logic [3:0]            nbytes,
    output logic [63:0]           hash0
);
    import sha512_pkg::*;

    word_t block_reg [BlockWords];
    word_t sched_reg [BlockWords];
    word_t work_reg  [HashWords];
    word_t hash_reg  [HashWords];
    word_t bits_reg;
    word_t new_word;
    word_t keep;
    word_t w;
    word_t s0;
    word_t s1;
    word_t t1;
    word_t t2;
    word_t a;
    word_t e;

    always_comb
    begin
        // Mask the final bytes and place the pad byte right after them.
        keep = (nbytes == 4'd0) ? '0 : ~(word_t'('1) >> (8 * nbytes));
        unique case (cmd.word_sel)
            SelData: new_word = (nbytes == 4'd8) ? data_word
                : ((data_word & keep) | (word_t'(8'h80) << (56 - 8 * nbytes)));
            SelPad:  new_word = {8'h80, 56'd0};
            SelZero: new_word = '0;
            SelLen:  new_word = bits_reg;
            default: new_word = '0;
        endcase
    end

    // Schedule is kept as a 16-word shift line; position 0 is the oldest.
    always_comb
    begin
        s1 = rotr(sched_reg[14], 19) ^ rotr(sched_reg[14], 61) ^ (sched_reg[14] >> 6);
        s0 = rotr(sched_reg[1], 1) ^ rotr(sched_reg[1], 8) ^ (sched_reg[1] >> 7);
        w = (cmd.rnd < 7'd16) ? block_reg[cmd.rnd[3:0]]
            : s1 + sched_reg[9] + s0 + sched_reg[0];
        a = work_reg[0];
        e = work_reg[4];
        t1 = work_reg[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
            + ((e & work_reg[5]) ^ (~e & work_reg[6])) + RoundK[cmd.rnd] + w;
        t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
            + ((a & work_reg[1]) ^ (a & work_reg[2]) ^ (work_reg[1] & work_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
        begin
            block_reg[cmd.widx] <= new_word;
        end
        if (cmd.round)
        begin
            for (int i = 0; i < BlockWords - 1; i++)
            begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[BlockWords-1] <= w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HashWords; i++)
            begin
                hash_reg[i] <= InitHash[i];
                work_reg[i] <= '0;
            end
            bits_reg <= '0;
        end
        else
        begin
            if (cmd.add_bits)
            begin
                bits_reg <= bits_reg + word_t'({nbytes, 3'b000});
            end
            if (cmd.start)
            begin
                for (int i = 0; i < HashWords; i++)
                begin
                    work_reg[i] <= hash_reg[i];
                end
            end
            else if (cmd.round)
            begin
                for (int i = 1; i < HashWords; i++)
                begin
                    work_reg[i] <= work_reg[i-1];
                end
                work_reg[4] <= work_reg[3] + t1;
                work_reg[0] <= t1 + t2;
            end
            if (cmd.finish)
            begin
                for (int i = 0; i < HashWords; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + work_reg[i];
                end
            end
            else if (cmd.shift_out)
            begin
                for (int i = 0; i < HashWords - 1; i++)
                begin
                    hash_reg[i] <= hash_reg[i+1];
                end
                hash_reg[HashWords-1] <= hash_reg[0];
            end
            if (cmd.reset_hash)
            begin
                for (int i = 0; i < HashWords; i++)
                begin
                    hash_reg[i] <= InitHash[i];
                end
                bits_reg <= '0;
            end
        end
    end

    assign hash0 = hash_reg[0];

endmodule

/* hw/rtl/sha512_ctrl.sv */
// Controller: input handshake, padding sequence, round counter and output.
module sha512_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_last,
    input  logic [3:0]              in_bytes,
    output logic                    in_ready,
    output logic [3:0]              nbytes,
    output logic                    out_valid,
    output logic                    out_last,
    input  logic                    out_ready,
    output sha512_pkg::sha512_cmd_t cmd
);
    import sha512_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_START, S_ROUND, S_FINISH, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    widx_t      widx_reg, widx_next;
    round_t     rnd_reg, rnd_next;
    logic       pad_reg, pad_next;      // pad byte still owed
    logic       fin_reg, fin_next;      // in the closing sequence
    logic       lenpend_reg, lenpend_next; // length goes into this block
    logic [2:0] ocnt_reg, ocnt_next;
    logic       take;

    assign in_ready  = (state_reg == S_IDLE);
    assign take      = in_valid && in_ready;
    assign nbytes    = !in_last ? 4'd8 : (in_bytes > 4'd8 ? 4'd8 : in_bytes);
    assign out_valid = (state_reg == S_OUT);
    assign out_last  = (ocnt_reg == 3'd7);

    always_comb
    begin
        state_next   = state_reg;
        widx_next    = widx_reg;
        rnd_next     = rnd_reg;
        pad_next     = pad_reg;
        fin_next     = fin_reg;
        lenpend_next = lenpend_reg;
        ocnt_next    = ocnt_reg;
        cmd          = '0;
        cmd.widx     = widx_reg;
        cmd.rnd      = rnd_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cmd.load_word = 1'b1;
                    cmd.word_sel  = SelData;
                    cmd.add_bits  = 1'b1;
                    widx_next     = widx_reg + 4'd1;
                    if (in_last)
                    begin
                        fin_next = 1'b1;
                        pad_next = (nbytes == 4'd8);
                        // The length needs the last two slots after the pad byte.
                        lenpend_next = (nbytes != 4'd8) && (widx_reg <= 4'd13);
                        state_next = (widx_reg == 4'd15) ? S_START : S_PAD;
                    end
                    else if (widx_reg == 4'd15)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_PAD:
            begin
                // Fill one slot per cycle: pad byte, zeros, then length.
                cmd.load_word = 1'b1;
                if (pad_reg)
                begin
                    cmd.word_sel = SelPad;
                    pad_next = 1'b0;
                    lenpend_next = (widx_reg <= 4'd13);
                end
                else if (widx_reg == 4'd15 && lenpend_reg)
                begin
                    cmd.word_sel = SelLen;
                end
                else
                begin
                    cmd.word_sel = SelZero;
                end
                widx_next = widx_reg + 4'd1;
                if (widx_reg == 4'd15)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.start = 1'b1;
                rnd_next  = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg + 7'd1;
                if (rnd_reg == 7'(Rounds - 1))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                if (!fin_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (lenpend_reg && !pad_reg)
                begin
                    ocnt_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    // The length did not fit, so a fresh block carries it.
                    lenpend_next = 1'b1;
                    state_next   = S_PAD;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    cmd.shift_out = 1'b1;
                    ocnt_next = ocnt_reg + 3'd1;
                    if (ocnt_reg == 3'd7)
                    begin
                        cmd.reset_hash = 1'b1;
                        fin_next     = 1'b0;
                        lenpend_next = 1'b0;
                        widx_next    = '0;
                        state_next   = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            widx_reg    <= '0;
            rnd_reg     <= '0;
            pad_reg     <= 1'b0;
            fin_reg     <= 1'b0;
            lenpend_reg <= 1'b0;
            ocnt_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            widx_reg    <= widx_next;
            rnd_reg     <= rnd_next;
            pad_reg     <= pad_next;
            fin_reg     <= fin_next;
            lenpend_reg <= lenpend_next;
            ocnt_reg    <= ocnt_next;
        end
    end

endmodule

/* hw/rtl/sha512_hash_engine_core.sv */
// SHA-512 engine: gathers 16-word blocks, pads the message, emits the digest.
// Words are accepted only in the idle state; a full block then runs a start step,
// 80 rounds on one shared round unit and a final add. The message end adds
// padding and one or two compressions, then 8 digest transactions. No word
// is taken while a block is compressed or the digest is sent. Reset loads
// the initial hash and clears the word index and length.
module sha512_hash_engine_core (
    input  logic clk,
    input  logic rst_n,
    sha512_in_if.sink    in_ch,
    sha512_out_if.source out_ch
);
    import sha512_pkg::*;

    sha512_cmd_t cmd;
    logic [3:0]  nbytes;

    sha512_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_last   (in_ch.last_word),
        .in_bytes  (in_ch.valid_bytes),
        .in_ready  (in_ch.ready),
        .nbytes    (nbytes),
        .out_valid (out_ch.valid),
        .out_last  (out_ch.digest_last),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    sha512_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_word (in_ch.data_word),
        .nbytes    (nbytes),
        .hash0     (out_ch.digest_word)
    );

endmodule
